### hw/rtl/hgf_pkg.sv
// ----------------------------------------------------------------------------
// hgf_pkg
// Shared widths, register indexes and types of the horizontal gradient filter.
// ----------------------------------------------------------------------------
package hgf_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int LINE_AW    = $clog2(MAX_WIDTH);

    localparam int PIX_W      = 8;
    localparam int SUM_W      = 10;   // three pixels: up to 765
    localparam int GRAD_W     = 11;
    localparam int COORD_W    = 12;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [COORD_W-1:0] WIDTH_RST_M1  = COORD_W'(640 - 1);
    localparam logic [COORD_W-1:0] HEIGHT_RST_M1 = COORD_W'(480 - 1);

    // Line store word: previous row and the row before it, same column.
    typedef struct packed {
        logic [PIX_W-1:0] row_m1;
        logic [PIX_W-1:0] row_m2;
    } t_line_word;

    localparam int LINE_DW = $bits(t_line_word);

    // Raster position of the beat being accepted.
    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic               interior;
        logic               last;
    } t_pos_info;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gradient_raw;
        logic [PIX_W-1:0]         pixel_out;
        logic [COORD_W-1:0]       center_x;
        logic [COORD_W-1:0]       center_y;
        logic                     frame_last;
    } t_result;

endpackage

### hw/rtl/hgf_pix_if.sv
// ----------------------------------------------------------------------------
// hgf_pix_if
// Pixel stream channel: one grayscale sample per beat.
// ----------------------------------------------------------------------------
interface hgf_pix_if
    import hgf_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

### hw/rtl/hgf_res_if.sv
// ----------------------------------------------------------------------------
// hgf_res_if
// Result stream channel: gradient, saved byte, centre and end-of-frame flag.
// ----------------------------------------------------------------------------
interface hgf_res_if
    import hgf_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [GRAD_W-1:0] gradient_raw;
    logic [PIX_W-1:0]         pixel_out;
    logic [COORD_W-1:0]       center_x;
    logic [COORD_W-1:0]       center_y;
    logic                     frame_last;

    modport source (output valid, output gradient_raw, output pixel_out,
                    output center_x, output center_y, output frame_last,
                    input ready);
    modport sink   (input valid, input gradient_raw, input pixel_out,
                    input center_x, input center_y, input frame_last,
                    output ready);
endinterface

### hw/rtl/hgf_line_ram.sv
// ----------------------------------------------------------------------------
// hgf_line_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hgf_line_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/hgf_raster_ctrl.sv
// ----------------------------------------------------------------------------
// hgf_raster_ctrl
// Frame size registers and column/row counters of the incoming raster.
// ----------------------------------------------------------------------------
module hgf_raster_ctrl
    import hgf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_accept,
    output t_pos_info            o_pos
);
    logic [COORD_W-1:0] r_wm1, n_wm1;
    logic [COORD_W-1:0] r_hm1, n_hm1;
    logic [COORD_W-1:0] r_col, n_col;
    logic [COORD_W-1:0] r_row, n_row;
    logic               cfg_hit;

    function automatic logic [COORD_W-1:0] clamp_m1(input logic [CFG_W-1:0] v,
                                                    input int unsigned    max_v);
        logic [COORD_W-1:0] res;
        if (v < CFG_W'(3)) begin
            res = COORD_W'(2);
        end else if (v > CFG_W'(max_v)) begin
            res = COORD_W'(max_v - 1);
        end else begin
            res = COORD_W'(v - CFG_W'(1));
        end
        return res;
    endfunction

    always_comb begin
        n_wm1   = r_wm1;
        n_hm1   = r_hm1;
        cfg_hit = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMAGE_WIDTH: begin
                    n_wm1   = clamp_m1(i_cfg_wdata, MAX_WIDTH);
                    cfg_hit = 1'b1;
                end
                REG_IMAGE_HEIGHT: begin
                    n_hm1   = clamp_m1(i_cfg_wdata, MAX_HEIGHT);
                    cfg_hit = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_hit) begin
            // restart the frame position
            n_col = '0;
            n_row = '0;
        end else if (i_accept) begin
            if (r_col == r_wm1) begin
                n_col = '0;
                n_row = (r_row == r_hm1) ? '0 : r_row + COORD_W'(1);
            end else begin
                n_col = r_col + COORD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wm1 <= WIDTH_RST_M1;
            r_hm1 <= HEIGHT_RST_M1;
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_wm1 <= n_wm1;
            r_hm1 <= n_hm1;
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_comb begin
        o_pos.col      = r_col;
        o_pos.center_x = r_col - COORD_W'(1);
        o_pos.center_y = r_row - COORD_W'(1);
        o_pos.interior = (r_col >= COORD_W'(2)) && (r_row >= COORD_W'(2));
        o_pos.last     = (r_col == r_wm1) && (r_row == r_hm1);
    end
endmodule

### hw/rtl/hgf_window.sv
// ----------------------------------------------------------------------------
// hgf_window
// Line store read-back stage: shifts the window, writes the rows back and
// forms the gradient of the finished window.
// ----------------------------------------------------------------------------
module hgf_window
    import hgf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  t_pos_info          i_pos,
    input  logic [PIX_W-1:0]   i_pixel,
    input  t_line_word         i_line_q,
    output logic               o_ram_we,
    output logic [LINE_AW-1:0] o_ram_waddr,
    output t_line_word         o_ram_wdata,
    output logic               o_busy,
    output logic               o_push,
    output t_result            o_result
);
    logic                     r_valid;
    t_pos_info                r_pos;
    logic [PIX_W-1:0]         r_bot;
    // Window kept as column sums: column x-1 and column x-2.
    logic [SUM_W-1:0]         r_sum_c1;
    logic [SUM_W-1:0]         r_sum_c2;
    logic [SUM_W-1:0]         col_sum;
    logic signed [GRAD_W-1:0] grad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_pos <= i_pos;
            r_bot <= i_pixel;
        end
        if (r_valid) begin
            r_sum_c2 <= r_sum_c1;
            r_sum_c1 <= col_sum;
        end
    end

    always_comb begin
        col_sum = SUM_W'(i_line_q.row_m2) + SUM_W'(i_line_q.row_m1) + SUM_W'(r_bot);
        grad    = $signed({1'b0, r_sum_c2}) - $signed({1'b0, col_sum});
    end

    // write back: current row moves to row y-1, old row y-1 to row y-2
    assign o_ram_we           = r_valid;
    assign o_ram_waddr        = r_pos.col[LINE_AW-1:0];
    assign o_ram_wdata.row_m1 = r_bot;
    assign o_ram_wdata.row_m2 = i_line_q.row_m1;

    assign o_busy = r_valid;
    assign o_push = r_valid && r_pos.interior;

    always_comb begin
        o_result.gradient_raw = grad;
        if (grad[GRAD_W-1]) begin
            o_result.pixel_out = '0;
        end else if (grad[GRAD_W-2:PIX_W] != '0) begin
            o_result.pixel_out = '1;
        end else begin
            o_result.pixel_out = grad[PIX_W-1:0];
        end
        o_result.center_x   = r_pos.center_x;
        o_result.center_y   = r_pos.center_y;
        o_result.frame_last = r_pos.last;
    end
endmodule

### hw/rtl/hgf_out_fifo.sv
// ----------------------------------------------------------------------------
// hgf_out_fifo
// Two-entry result queue decoupling the window stage from the output ready.
// ----------------------------------------------------------------------------
module hgf_out_fifo
    import hgf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_result    i_data,
    input  logic       i_pop,
    output logic       o_valid,
    output t_result    o_data,
    output logic [1:0] o_count
);
    t_result    r_mem [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_count, n_count;

    always_comb begin
        n_wp    = i_push ? ~r_wp : r_wp;
        n_rp    = i_pop  ? ~r_rp : r_rp;
        n_count = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_count;
endmodule

### hw/rtl/horizontal_gradient_3x3_filter.sv
// ----------------------------------------------------------------------------
// horizontal_gradient_3x3_filter
// 3x3 horizontal gradient over a raster pixel stream, two rows held in RAM.
//
//   channel   dir  beat contents
//   i_pix     in   pixel_in
//   o_res     out  gradient_raw, pixel_out, center_x, center_y, frame_last
//   i_cfg_*   in   register index, write data (image_width, image_height)
//
// One pixel per clock while i_pix.ready is high. A pixel reads its column of the
// line RAM at accept, the next cycle writes the column back and forms the
// gradient; the result waits in the result queue that drives o_res.
// The line RAM is not cleared after reset: the first two rows of every frame
// rewrite each column before it feeds a result.
// A stalled o_res drops i_pix.ready once the two-entry result queue could
// not also take the beat still in flight.
// ----------------------------------------------------------------------------
module horizontal_gradient_3x3_filter
    import hgf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    hgf_pix_if.sink              i_pix,
    hgf_res_if.source            o_res
);
    t_pos_info          pos;
    logic               accept;
    logic               ram_we;
    logic [LINE_AW-1:0] ram_waddr;
    t_line_word         ram_wdata;
    t_line_word         ram_q;
    logic               busy;
    logic               push;
    logic               pop;
    t_result            win_res;
    t_result            fifo_res;
    logic               fifo_valid;
    logic [1:0]         fifo_count;

    // take a beat only if the queue can hold whatever is still in flight
    assign i_pix.ready = (fifo_count == 2'd0)
                      || ((fifo_count == 2'd1) && (!busy || pop))
                      || ((fifo_count == 2'd2) && !busy && pop);
    assign accept = i_pix.valid && i_pix.ready;
    assign pop    = fifo_valid && o_res.ready;

    hgf_raster_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .o_pos       (pos)
    );

    hgf_line_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (LINE_DW)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (pos.col[LINE_AW-1:0]),
        .o_rdata (ram_q)
    );

    hgf_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_pos       (pos),
        .i_pixel     (i_pix.pixel_in),
        .i_line_q    (ram_q),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_busy      (busy),
        .o_push      (push),
        .o_result    (win_res)
    );

    hgf_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (win_res),
        .i_pop   (pop),
        .o_valid (fifo_valid),
        .o_data  (fifo_res),
        .o_count (fifo_count)
    );

    assign o_res.valid        = fifo_valid;
    assign o_res.gradient_raw = fifo_res.gradient_raw;
    assign o_res.pixel_out    = fifo_res.pixel_out;
    assign o_res.center_x     = fifo_res.center_x;
    assign o_res.center_y     = fifo_res.center_y;
    assign o_res.frame_last   = fifo_res.frame_last;

    a_fifo_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && (fifo_count == 2'd2) && !pop))
        else $error("result queue overflow");

    a_ram_no_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(accept && ram_we && (pos.col[LINE_AW-1:0] == ram_waddr)))
        else $error("line RAM read and write hit the same column");

    a_push_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> $past(accept))
        else $error("result pushed without a pixel accepted the cycle before");

    a_byte_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.gradient_raw[GRAD_W-1]) |-> (o_res.pixel_out == '0))
        else $error("negative gradient not clamped to zero");
endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the horizontal gradient filter. Streams pixels under
// many frame geometries with random gaps on the pixel side and random stalls
// on the result side. Every result beat is matched in order against a
// software copy of the line stores, the 3x3 window and the raster position.
// ----------------------------------------------------------------------------
module tb_top;
    import hgf_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 7;
    localparam int RESET_PIXELS  = 40;
    localparam int RANDOM_PIXELS = 1000;
    localparam int WIDE_PIXELS   = 80;
    localparam int TALL_ROWS     = 30;
    localparam int DRAIN_CYCLES  = 8;
    localparam int END_WAIT_MAX  = 5000;
    localparam int CYCLE_LIMIT   = 6_000_000;
    localparam int REPORT_MAX    = 20;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3  = CFG_IDX_W'(3);
    localparam logic [CFG_W-1:0]     CFG_ALL_ONES = '1;

    typedef enum logic {STEP_REG, STEP_PIXEL} t_step_kind;
    typedef enum int {PIX_RANDOM, PIX_EXTREME, PIX_NEAR_EDGE} t_pix_style;

    typedef struct packed {
        t_step_kind           kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;     // register value, or pixel in the low byte
        logic                 has_res;
        t_result              res;
    } t_step;

    localparam t_result NO_RES  = '0;
    localparam int      N_STEPS = 21;

    // 3 wide (width 0 clamps up), 6 tall: left column bright for three rows,
    // right column bright for the next three, so the gradient sweeps from
    // +765 down to -765 and both byte clamps are hit.
    localparam t_step DIRECTED [N_STEPS] = '{
        '{STEP_REG,   REG_IMAGE_WIDTH,  13'd0,        1'b0, NO_RES},
        '{STEP_REG,   REG_IMAGE_HEIGHT, 13'd6,        1'b0, NO_RES},
        '{STEP_PIXEL, '0,               13'd255,      1'b0, NO_RES},
        '{STEP_PIXEL, '0,               13'd17,       1'b0, NO_RES},
        '{STEP_PIXEL, '0,               13'd0,        1'b0, NO_RES},
        '{STEP_PIXEL, '0,               13'd255,      1'b0, NO_RES},
        '{STEP_PIXEL, '0,               13'd200,      1'b0, NO_RES},
        '{STEP_PIXEL, '0,               13'd0,        1'b0, NO_RES},
        '{STEP_REG,   REG_SPARE_3,      CFG_ALL_ONES, 1'b0, NO_RES},
        '{STEP_PIXEL, '0,               13'd255,      1'b0, NO_RES},
        '{STEP_PIXEL, '0,               13'd99,       1'b0, NO_RES},
        '{STEP_PIXEL, '0,               13'd0,        1'b1,
          '{11'sd765, 8'd255, 12'd1, 12'd1, 1'b0}},
        '{STEP_PIXEL, '0,               13'd0,        1'b0, NO_RES},
        '{STEP_PIXEL, '0,               13'd128,      1'b0, NO_RES},
        '{STEP_PIXEL, '0,               13'd255,      1'b1,
          '{11'sd255, 8'd255, 12'd1, 12'd2, 1'b0}},
        '{STEP_PIXEL, '0,               13'd0,        1'b0, NO_RES},
        '{STEP_PIXEL, '0,               13'd61,       1'b0, NO_RES},
        '{STEP_PIXEL, '0,               13'd255,      1'b1,
          '{-11'sd255, 8'd0, 12'd1, 12'd3, 1'b0}},
        '{STEP_PIXEL, '0,               13'd0,        1'b0, NO_RES},
        '{STEP_PIXEL, '0,               13'd1,        1'b0, NO_RES},
        '{STEP_PIXEL, '0,               13'd255,      1'b1,
          '{-11'sd765, 8'd0, 12'd1, 12'd4, 1'b1}}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_wdata;

    hgf_pix_if pix_if ();
    hgf_res_if res_if ();

    horizontal_gradient_3x3_filter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (pix_if),
        .o_res       (res_if)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Shadow of the filter state.
    logic [CFG_W-1:0] cfg_width  = CFG_W'(640);
    logic [CFG_W-1:0] cfg_height = CFG_W'(480);
    logic [PIX_W-1:0] line_m1 [MAX_WIDTH] = '{default: '0};
    logic [PIX_W-1:0] line_m2 [MAX_WIDTH] = '{default: '0};
    logic [PIX_W-1:0] win_regs [9]        = '{default: '0};
    int unsigned      col_pos = 0;
    int unsigned      row_pos = 0;

    t_result grad_expect_q [$];
    t_result got_res;
    t_result want_res;

    int  pixels_sent     = 0;
    int  results_checked = 0;
    int  reg_writes      = 0;
    int  fail_count      = 0;
    int  cycle_count     = 0;
    bit  send_quiet      = 1'b0;

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int pick_len();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 3);
    endfunction

    function automatic logic [PIX_W-1:0] next_pixel(input t_pix_style style);
        case (style)
            PIX_EXTREME:   return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            PIX_NEAR_EDGE: return PIX_W'($urandom_range(0, 1) ? $urandom_range(0, 7)
                                                              : $urandom_range(248, 255));
            default:       return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic note_reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        if (idx == REG_IMAGE_WIDTH) begin
            cfg_width = data;
            col_pos   = 0;
            row_pos   = 0;
        end else if (idx == REG_IMAGE_HEIGHT) begin
            cfg_height = data;
            col_pos    = 0;
            row_pos    = 0;
        end
    endtask

    // Shift one pixel through the line stores and window; return the gradient
    // when the window sits on an interior centre.
    task automatic advance_gradient(input logic [PIX_W-1:0] pix, output bit has_res,
                                    output t_result res);
        int unsigned      w, h, x, y;
        int               r, left_sum, right_sum, grad;
        logic [PIX_W-1:0] mid, top;
        w = clamp_dim(cfg_width, MAX_WIDTH);
        h = clamp_dim(cfg_height, MAX_HEIGHT);
        x = col_pos;
        y = row_pos;
        if (x >= w) x = 0;
        if (y >= h) y = 0;
        mid = line_m1[x];
        top = line_m2[x];
        line_m2[x] = mid;
        line_m1[x] = pix;
        for (r = 0; r < 3; r++) begin
            win_regs[r*3]   = win_regs[r*3+1];
            win_regs[r*3+1] = win_regs[r*3+2];
        end
        win_regs[2] = top;
        win_regs[5] = mid;
        win_regs[8] = pix;
        has_res = (x >= 2) && (y >= 2);
        res     = '0;
        if (has_res) begin
            left_sum  = int'(win_regs[0]) + int'(win_regs[3]) + int'(win_regs[6]);
            right_sum = int'(win_regs[2]) + int'(win_regs[5]) + int'(win_regs[8]);
            grad      = left_sum - right_sum;
            res.gradient_raw = GRAD_W'(grad);
            res.pixel_out    = (grad < 0) ? 8'd0 : (grad > 255) ? 8'd255 : PIX_W'(grad);
            res.center_x     = COORD_W'(x - 1);
            res.center_y     = COORD_W'(y - 1);
            res.frame_last   = (x == w - 1) && (y == h - 1);
        end
        x++;
        if (x >= w) begin
            x = 0;
            y++;
            if (y >= h) y = 0;
        end
        col_pos = x;
        row_pos = y;
    endtask

    task automatic push_pixel(input logic [PIX_W-1:0] pix, input bit typed, input bit typed_has,
                              input t_result typed_res);
        int      gap;
        bit      has_res;
        t_result res;
        if ($urandom_range(0, 199) == 0) send_quiet = !send_quiet;
        gap = (!send_quiet && $urandom_range(0, 2) == 0) ? pick_len() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_if.valid    <= 1'b1;
        pix_if.pixel_in <= pix;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        advance_gradient(pix, has_res, res);
        if (typed) begin
            has_res = typed_has;
            res     = typed_res;
        end
        if (has_res) grad_expect_q.push_back(res);
        pixels_sent++;
    endtask

    // Drop valid, let every expected gradient come out, then cover pixels
    // still in the pipe that produce nothing.
    task automatic wait_drained();
        @(negedge i_clk);
        pix_if.valid <= 1'b0;
        while (grad_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        note_reg_write(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        reg_writes++;
    endtask

    // Result side: random back-pressure with quiet stretches.
    initial begin
        int stall_left;
        bit quiet;
        stall_left   = 0;
        quiet        = 1'b0;
        res_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 299) == 0) quiet = !quiet;
            if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0) stall_left = pick_len();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got_res.gradient_raw = res_if.gradient_raw;
            got_res.pixel_out    = res_if.pixel_out;
            got_res.center_x     = res_if.center_x;
            got_res.center_y     = res_if.center_y;
            got_res.frame_last   = res_if.frame_last;
            if (grad_expect_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("%0t unexpected result beat: gradient %0d at (%0d,%0d)",
                             $time, got_res.gradient_raw, got_res.center_x, got_res.center_y);
            end else begin
                want_res = grad_expect_q.pop_front();
                results_checked++;
                if (got_res !== want_res) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        if (got_res.gradient_raw !== want_res.gradient_raw)
                            $display("%0t gradient_raw expected %0d got %0d", $time,
                                     want_res.gradient_raw, got_res.gradient_raw);
                        if (got_res.pixel_out !== want_res.pixel_out)
                            $display("%0t pixel_out expected %0d got %0d", $time,
                                     want_res.pixel_out, got_res.pixel_out);
                        if (got_res.center_x !== want_res.center_x)
                            $display("%0t center_x expected %0d got %0d", $time,
                                     want_res.center_x, got_res.center_x);
                        if (got_res.center_y !== want_res.center_y)
                            $display("%0t center_y expected %0d got %0d", $time,
                                     want_res.center_y, got_res.center_y);
                        if (got_res.frame_last !== want_res.frame_last)
                            $display("%0t frame_last expected %0b got %0b", $time,
                                     want_res.frame_last, got_res.frame_last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t timeout with %0d gradients outstanding", $time, grad_expect_q.size());
            $display("[horizontal_gradient_3x3_filter] ERROR");
            $finish;
        end
    end

    initial begin
        int          i, k, w_pick, h_pick, frame_px, n_px, split, random_px, waited;
        t_pix_style  style;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_wdata     = '0;
        pix_if.valid    = 1'b0;
        pix_if.pixel_in = '0;
        random_px       = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry: the head of a 640-wide first row yields nothing.
        repeat (RESET_PIXELS)
            push_pixel(next_pixel(PIX_RANDOM), 1'b1, 1'b0, NO_RES);

        for (i = 0; i < N_STEPS; i++) begin
            if (DIRECTED[i].kind == STEP_REG) begin
                wait_drained();
                write_reg(DIRECTED[i].idx, DIRECTED[i].data);
            end else begin
                push_pixel(DIRECTED[i].data[PIX_W-1:0], 1'b1, DIRECTED[i].has_res,
                           DIRECTED[i].res);
            end
        end

        while (random_px < RANDOM_PIXELS) begin
            wait_drained();
            case ($urandom_range(0, 9))
                0:       w_pick = $urandom_range(0, 2);
                1:       w_pick = $urandom_range(11, 40);
                default: w_pick = $urandom_range(3, 10);
            endcase
            case ($urandom_range(0, 9))
                0:       h_pick = $urandom_range(0, 2);
                1:       h_pick = $urandom_range(7, 12);
                default: h_pick = $urandom_range(3, 6);
            endcase
            case ($urandom_range(0, 3))
                0: write_reg(REG_IMAGE_WIDTH, CFG_W'(w_pick));
                1: write_reg(REG_IMAGE_HEIGHT, CFG_W'(h_pick));
                2: begin
                    write_reg(REG_IMAGE_HEIGHT, CFG_W'(h_pick));
                    write_reg(REG_IMAGE_WIDTH, CFG_W'(w_pick));
                end
                default: begin
                    write_reg(REG_IMAGE_WIDTH, CFG_W'(w_pick));
                    write_reg(REG_IMAGE_HEIGHT, CFG_W'(h_pick));
                end
            endcase
            frame_px = clamp_dim(cfg_width, MAX_WIDTH) * clamp_dim(cfg_height, MAX_HEIGHT);
            style    = t_pix_style'($urandom_range(0, 2));
            n_px     = frame_px * $urandom_range(1, 2);
            split    = 0;
            case ($urandom_range(0, 7))
                // cut the frame short; the next register write restarts it
                0: n_px = $urandom_range(1, frame_px - 1);
                // pause mid-frame and poke a spare index, which must not restart it
                1: split = $urandom_range(1, frame_px - 1);
                default: ;
            endcase
            // hold the random part to its pixel budget
            if (n_px > RANDOM_PIXELS - random_px) n_px = RANDOM_PIXELS - random_px;
            for (k = 0; k < n_px; k++) begin
                if (split != 0 && k == split) begin
                    wait_drained();
                    write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                              CFG_W'($urandom));
                end
                push_pixel(next_pixel(style), 1'b0, 1'b0, NO_RES);
            end
            random_px += n_px;
        end

        // All-ones register values clamp to the widest and the tallest frame;
        // run the head of each.
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, CFG_ALL_ONES);
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(3));
        repeat (WIDE_PIXELS)
            push_pixel(next_pixel(t_pix_style'($urandom_range(0, 2))), 1'b0, 1'b0, NO_RES);
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, CFG_W'(3));
        write_reg(REG_IMAGE_HEIGHT, CFG_ALL_ONES);
        repeat (3 * TALL_ROWS)
            push_pixel(next_pixel(t_pix_style'($urandom_range(0, 2))), 1'b0, 1'b0, NO_RES);

        @(negedge i_clk);
        pix_if.valid <= 1'b0;
        waited = 0;
        while (grad_expect_q.size() != 0 && waited < END_WAIT_MAX) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (grad_expect_q.size() != 0) begin
            fail_count++;
            $display("%0t %0d expected gradients never arrived", $time, grad_expect_q.size());
        end

        $display("sent %0d pixels, checked %0d gradients, %0d register writes, %0d mismatches",
                 pixels_sent, results_checked, reg_writes, fail_count);
        $display("geometries from clamped 3x3 frames to the heads of 4096-wide and 4096-tall "
                 , "frames, cut frames and spare-index writes mid-frame");
        if (fail_count == 0) begin
            $display("[horizontal_gradient_3x3_filter] OK");
        end else begin
            $display("[horizontal_gradient_3x3_filter] ERROR");
        end
        $finish;
    end

endmodule
